// File: sv/camera_line_packet_deframer_macros.svh
// Assertion macros shared by the deframer modules.
`ifndef CAMERA_LINE_PACKET_DEFRAMER_MACROS_SVH
`define CAMERA_LINE_PACKET_DEFRAMER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CLPD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Check a property that must also hold while reset is asserted.
`define CLPD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// File: sv/clpd_pkg.sv
// Shared constants, codes and types of the camera line packet deframer.
package clpd_pkg;

    // Geometry of one camera line
    localparam int unsigned FRAME_WIDTH  = 160;
    localparam int unsigned FRAME_HEIGHT = 120;

    localparam int unsigned LINE_BYTES = 2 * FRAME_WIDTH;   // payload bytes per line
    localparam int unsigned ROW_DEPTH  = 2 * FRAME_WIDTH;   // two halves, one line each
    localparam int unsigned ADDR_W     = $clog2(ROW_DEPTH);
    localparam int unsigned X_W        = $clog2(2 * FRAME_WIDTH);
    localparam int unsigned PIXEL_W    = 16;

    // Packet framing bytes
    localparam logic [7:0] HEAD_FIRST  = 8'hA5;
    localparam logic [7:0] HEAD_SECOND = 8'h5A;
    localparam logic [7:0] TYPE_LINE   = 8'h01;

    // Input command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result kind codes
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    typedef enum logic [1:0] {
        ST_LINE_OK  = 2'd0,
        ST_SUM_BAD  = 2'd1,
        ST_HDR_SKIP = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        PH_HEAD1   = 4'd0,
        PH_HEAD2   = 4'd1,
        PH_TYPE    = 4'd2,
        PH_LINE    = 4'd3,
        PH_LENHI   = 4'd4,
        PH_LENLO   = 4'd5,
        PH_SKIP    = 4'd6,
        PH_SKIPSUM = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_SUM     = 4'd9
    } t_phase;

    typedef struct packed {
        logic                   en;
        logic [ADDR_W-1:0]      addr;
        logic [PIXEL_W-1:0]     data;
    } t_ram_wr;

    typedef struct packed {
        logic                   en;
        logic [ADDR_W-1:0]      addr;
    } t_ram_rd;

    typedef struct packed {
        logic                   valid;
        t_status                status;
        logic [7:0]             line;
        logic                   frame_start;
        logic                   frame_end;
        logic                   first_frame;
    } t_stat_evt;

    typedef struct packed {
        logic                   valid;
        logic [7:0]             line;
    } t_line_load;

    typedef struct packed {
        logic                   valid;
        logic [15:0]            pix_x;
        logic [8:0]             pix_y;
        logic                   last;
    } t_pix_evt;

    typedef struct packed {
        logic                   kind;
        t_status                status;
        logic [7:0]             line;
        logic                   frame_start;
        logic                   frame_end;
        logic                   first_frame;
        logic [15:0]            pix_x;
        logic [8:0]             pix_y;
        logic [PIXEL_W-1:0]     pixel;
        logic                   last;
    } t_out_item;

endpackage

// File: sv/clpd_if.sv
// Valid/ready channel interfaces for the deframer input and result streams.
interface clpd_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] link_byte;

    modport source (output valid, output cmd, output link_byte, input ready);
    modport sink   (input valid, input cmd, input link_byte, output ready);
endinterface

interface clpd_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  status;
    logic [7:0]  line;
    logic        frame_start;
    logic        frame_end;
    logic        first_frame;
    logic [15:0] pix_x;
    logic [8:0]  pix_y;
    logic [15:0] pixel;
    logic        last;

    modport source (
        output valid, output kind, output status, output line,
        output frame_start, output frame_end, output first_frame,
        output pix_x, output pix_y, output pixel, output last,
        input ready
    );
    modport sink (
        input valid, input kind, input status, input line,
        input frame_start, input frame_end, input first_frame,
        input pix_x, input pix_y, input pixel, input last,
        output ready
    );
endinterface

// File: sv/clpd_row_ram.sv
// Simple dual-port synchronous RAM with registered, enabled read.
module clpd_row_ram #(
    parameter int unsigned DEPTH = 320,
    parameter int unsigned WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: hold data until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// File: sv/clpd_parser.sv
// Packet parser: header checks, checksum, and row store writes.
`include "camera_line_packet_deframer_macros.svh"

module clpd_parser (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_byte_valid,
    input  logic [7:0]             i_byte,
    output clpd_pkg::t_ram_wr      o_wr,
    output clpd_pkg::t_stat_evt    o_stat,
    output clpd_pkg::t_line_load   o_load,
    output logic                   o_fill_half
);

    clpd_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_kind, n_kind;
    logic [7:0]       r_line, n_line;
    logic [15:0]      r_len, n_len;
    logic [15:0]      r_count, n_count;
    logic [7:0]       r_high, n_high;
    logic             r_fill, n_fill;
    logic             r_first_seen, n_first_seen;

    logic [16:0]      cnt_inc;
    logic             skip_done;
    logic             pay_done;
    logic [15:0]      full_len;
    logic             hdr_ok;
    logic             frame_start;

    // Shared compares
    always_comb begin
        cnt_inc     = {1'b0, r_count} + 17'd1;
        skip_done   = cnt_inc >= {1'b0, r_len};
        pay_done    = cnt_inc >= 17'(clpd_pkg::LINE_BYTES);
        full_len    = {r_len[15:8], i_byte};
        hdr_ok      = (r_kind == clpd_pkg::TYPE_LINE)
                   && (r_line < 8'(clpd_pkg::FRAME_HEIGHT))
                   && (full_len == 16'(clpd_pkg::LINE_BYTES));
        frame_start = (r_line == 8'd0);
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_byte_valid) begin
            unique case (r_phase)
                clpd_pkg::PH_HEAD1: begin
                    if (i_byte == clpd_pkg::HEAD_FIRST) n_phase = clpd_pkg::PH_HEAD2;
                end
                clpd_pkg::PH_HEAD2: begin
                    n_phase = (i_byte == clpd_pkg::HEAD_SECOND) ? clpd_pkg::PH_TYPE
                                                                : clpd_pkg::PH_HEAD1;
                end
                clpd_pkg::PH_TYPE:  n_phase = clpd_pkg::PH_LINE;
                clpd_pkg::PH_LINE:  n_phase = clpd_pkg::PH_LENHI;
                clpd_pkg::PH_LENHI: n_phase = clpd_pkg::PH_LENLO;
                clpd_pkg::PH_LENLO: begin
                    if (hdr_ok)              n_phase = clpd_pkg::PH_PAYLOAD;
                    else if (full_len == '0) n_phase = clpd_pkg::PH_SKIPSUM;
                    else                     n_phase = clpd_pkg::PH_SKIP;
                end
                clpd_pkg::PH_SKIP: begin
                    if (skip_done) n_phase = clpd_pkg::PH_SKIPSUM;
                end
                clpd_pkg::PH_SKIPSUM: n_phase = clpd_pkg::PH_HEAD1;
                clpd_pkg::PH_PAYLOAD: begin
                    if (pay_done) n_phase = clpd_pkg::PH_SUM;
                end
                clpd_pkg::PH_SUM: n_phase = clpd_pkg::PH_HEAD1;
                default:          n_phase = clpd_pkg::PH_HEAD1;
            endcase
        end
    end

    // Datapath updates, store writes and status events
    always_comb begin
        n_sum        = r_sum;
        n_kind       = r_kind;
        n_line       = r_line;
        n_len        = r_len;
        n_count      = r_count;
        n_high       = r_high;
        n_fill       = r_fill;
        n_first_seen = r_first_seen;
        o_wr         = '0;
        o_stat       = '0;
        o_load       = '0;
        if (i_byte_valid) begin
            unique case (r_phase)
                clpd_pkg::PH_HEAD1, clpd_pkg::PH_HEAD2: begin
                end
                clpd_pkg::PH_TYPE: begin
                    n_kind = i_byte;
                    n_sum  = i_byte;
                end
                clpd_pkg::PH_LINE: begin
                    n_line = i_byte;
                    n_sum  = r_sum + i_byte;
                end
                clpd_pkg::PH_LENHI: begin
                    n_len = {i_byte, 8'h00};
                    n_sum = r_sum + i_byte;
                end
                clpd_pkg::PH_LENLO: begin
                    n_len   = full_len;
                    n_sum   = r_sum + i_byte;
                    n_count = '0;
                end
                clpd_pkg::PH_SKIP: begin
                    n_count = cnt_inc[15:0];
                end
                clpd_pkg::PH_SKIPSUM: begin
                    o_stat.valid  = 1'b1;
                    o_stat.status = clpd_pkg::ST_HDR_SKIP;
                    o_stat.line   = r_line;
                end
                clpd_pkg::PH_PAYLOAD: begin
                    n_sum   = r_sum + i_byte;
                    n_count = cnt_inc[15:0];
                    // Even byte holds the pixel high half, odd byte completes it
                    if (!r_count[0]) begin
                        n_high = i_byte;
                    end else begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = (r_fill ? clpd_pkg::ADDR_W'(clpd_pkg::FRAME_WIDTH) : '0)
                                  + clpd_pkg::ADDR_W'(r_count >> 1);
                        o_wr.data = {r_high, i_byte};
                    end
                end
                clpd_pkg::PH_SUM: begin
                    o_stat.valid = 1'b1;
                    o_stat.line  = r_line;
                    if (r_sum != i_byte) begin
                        o_stat.status = clpd_pkg::ST_SUM_BAD;
                    end else begin
                        o_stat.status      = clpd_pkg::ST_LINE_OK;
                        o_stat.frame_start = frame_start;
                        o_stat.frame_end   = (r_line == 8'(clpd_pkg::FRAME_HEIGHT - 1));
                        o_stat.first_frame = frame_start && !r_first_seen;
                        n_first_seen       = r_first_seen | frame_start;
                        o_load.valid       = 1'b1;
                        o_load.line        = r_line;
                        n_fill             = ~r_fill;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= clpd_pkg::PH_HEAD1;
            r_fill       <= 1'b0;
            r_first_seen <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_fill       <= n_fill;
            r_first_seen <= n_first_seen;
        end
    end

    // Packet fields
    always_ff @(posedge i_clk) begin
        r_sum   <= n_sum;
        r_kind  <= n_kind;
        r_line  <= n_line;
        r_len   <= n_len;
        r_count <= n_count;
        r_high  <= n_high;
    end

    assign o_fill_half = r_fill;

    `CLPD_ASSERT(a_wr_in_fill_half, i_clk, i_rst_n,
        o_wr.en |-> ((o_wr.addr >= clpd_pkg::ADDR_W'(clpd_pkg::FRAME_WIDTH)) == r_fill))
    `CLPD_ASSERT(a_stat_ends_packet, i_clk, i_rst_n,
        o_stat.valid |=> (r_phase == clpd_pkg::PH_HEAD1))

endmodule

// File: sv/clpd_drain.sv
// Line drain: walks the pending line as a 2x2 upscaled pixel stream.
`include "camera_line_packet_deframer_macros.svh"

module clpd_drain (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_tick,
    input  clpd_pkg::t_line_load   i_load,
    input  logic                   i_fill_half,
    output clpd_pkg::t_ram_rd      o_rd,
    output clpd_pkg::t_pix_evt     o_pix
);

    localparam logic [clpd_pkg::X_W-1:0] XLast = clpd_pkg::X_W'(2 * clpd_pkg::FRAME_WIDTH - 1);

    logic                     r_pending;
    logic [7:0]               r_pline;
    logic [clpd_pkg::X_W-1:0] r_x;
    logic                     r_row;

    // Read the half not being filled
    always_comb begin
        o_rd.en     = i_tick && r_pending;
        o_rd.addr   = (i_fill_half ? '0 : clpd_pkg::ADDR_W'(clpd_pkg::FRAME_WIDTH))
                    + clpd_pkg::ADDR_W'(r_x >> 1);
        o_pix.valid = o_rd.en;
        o_pix.pix_x = 16'(r_x);
        o_pix.pix_y = {r_pline, r_row};
        o_pix.last  = r_row && (r_x == XLast);
    end

    // Load a new line or advance the drain position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_x       <= '0;
            r_row     <= 1'b0;
        end else if (i_load.valid) begin
            r_pending <= 1'b1;
            r_x       <= '0;
            r_row     <= 1'b0;
        end else if (o_rd.en) begin
            if (r_x == XLast) begin
                r_x   <= '0;
                r_row <= ~r_row;
                if (r_row) r_pending <= 1'b0;
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
    end

    // Line index of the pending line
    always_ff @(posedge i_clk) begin
        if (i_load.valid) r_pline <= i_load.line;
    end

    `CLPD_ASSERT(a_last_ends_line, i_clk, i_rst_n,
        (o_pix.valid && o_pix.last) |=> !r_pending)
    `CLPD_ASSERT_ALWAYS(a_load_not_tick, i_clk,
        !(i_load.valid && i_tick))

endmodule

// File: sv/camera_line_packet_deframer.sv
// Top level of the camera line packet deframer.
// One item per ready clock: a link byte (cmd 0) or a display read tick (cmd 1).
// Link bytes are parsed into A5 5A framed line packets; each accepted payload of
// FRAME_WIDTH big-endian RGB565 pixels fills one half of a ping-pong row RAM, and a
// packet end gives one status result. Read ticks drain the last good line as a 2x2
// upscaled stream of 4*FRAME_WIDTH pixel results; a tick with no line pending gives
// none. Sustained rate is one item per cycle while the output is ready. Each result
// passes the stage 1 register, held there during the registered row RAM read, and
// then the output register. The row RAM needs no clearing pass after reset.
`include "camera_line_packet_deframer_macros.svh"

module camera_line_packet_deframer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    clpd_in_if.sink           i_in,
    clpd_out_if.source        o_out
);

    logic                         in_acc;
    logic                         byte_valid;
    logic                         tick;
    logic                         out_free;
    logic                         s1_ready;

    clpd_pkg::t_ram_wr            wr;
    clpd_pkg::t_ram_rd            rd;
    clpd_pkg::t_stat_evt          stat;
    clpd_pkg::t_line_load         load;
    clpd_pkg::t_pix_evt           pix;
    logic                         fill_half;
    logic [clpd_pkg::PIXEL_W-1:0] rdata;

    clpd_pkg::t_out_item          n_s1;
    logic                         r_s1_valid;
    clpd_pkg::t_out_item          r_s1;
    logic                         r_o_valid;
    clpd_pkg::t_out_item          n_o;
    clpd_pkg::t_out_item          r_o;

    // Handshake
    always_comb begin
        out_free   = !r_o_valid || o_out.ready;
        s1_ready   = !r_s1_valid || out_free;
        in_acc     = i_in.valid && s1_ready;
        byte_valid = in_acc && (i_in.cmd == clpd_pkg::CMD_BYTE);
        tick       = in_acc && (i_in.cmd == clpd_pkg::CMD_TICK);
    end

    assign i_in.ready = s1_ready;

    clpd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (byte_valid),
        .i_byte       (i_in.link_byte),
        .o_wr         (wr),
        .o_stat       (stat),
        .o_load       (load),
        .o_fill_half  (fill_half)
    );

    clpd_drain u_drain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick),
        .i_load       (load),
        .i_fill_half  (fill_half),
        .o_rd         (rd),
        .o_pix        (pix)
    );

    clpd_row_ram #(
        .DEPTH (clpd_pkg::ROW_DEPTH),
        .WIDTH (clpd_pkg::PIXEL_W)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (rd.en),
        .i_raddr (rd.addr),
        .o_rdata (rdata)
    );

    // Build the result item; the pixel value joins from the RAM one stage later
    always_comb begin
        n_s1 = '0;
        if (pix.valid) begin
            n_s1.kind  = clpd_pkg::KIND_PIXEL;
            n_s1.pix_x = pix.pix_x;
            n_s1.pix_y = pix.pix_y;
            n_s1.last  = pix.last;
        end else begin
            n_s1.kind        = clpd_pkg::KIND_STATUS;
            n_s1.status      = stat.status;
            n_s1.line        = stat.line;
            n_s1.frame_start = stat.frame_start;
            n_s1.frame_end   = stat.frame_end;
            n_s1.first_frame = stat.first_frame;
        end
    end

    // Stage 1: hold the item while the RAM read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= stat.valid || pix.valid;
        end else if (out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) r_s1 <= n_s1;
    end

    // Output register: advance when empty or taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_s1_valid;
        end
    end

    // Merge the RAM data into a pixel item
    always_comb begin
        n_o       = r_s1;
        n_o.pixel = (r_s1.kind == clpd_pkg::KIND_PIXEL) ? rdata : '0;
    end

    always_ff @(posedge i_clk) begin
        if (out_free) r_o <= n_o;
    end

    // Drive the result channel
    always_comb begin
        o_out.valid       = r_o_valid;
        o_out.kind        = r_o.kind;
        o_out.status      = r_o.status;
        o_out.line        = r_o.line;
        o_out.frame_start = r_o.frame_start;
        o_out.frame_end   = r_o.frame_end;
        o_out.first_frame = r_o.first_frame;
        o_out.pix_x       = r_o.pix_x;
        o_out.pix_y       = r_o.pix_y;
        o_out.pixel       = r_o.pixel;
        o_out.last        = r_o.last;
    end

    `CLPD_ASSERT_ALWAYS(a_no_rd_wr_same_cycle, i_clk,
        !(rd.en && wr.en))
    `CLPD_ASSERT_ALWAYS(a_one_event_per_item, i_clk,
        !(stat.valid && pix.valid))
    `CLPD_ASSERT(a_pixel_enters_stage, i_clk, i_rst_n,
        (tick && pix.valid) |=> (r_s1_valid && (r_s1.kind == clpd_pkg::KIND_PIXEL)))

endmodule
